// ===== sv/epc_pkg.sv =====
// Shared types, constants and helpers for the egress packet classifier.
package epc_pkg;

  localparam int unsigned PAYLOAD_LIMIT_DEF = 512;

  localparam logic [3:0]  VER_IPV4         = 4'd4;
  localparam logic [3:0]  VER_IPV6         = 4'd6;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [15:0] DNS_PORT         = 16'd53;
  localparam logic [7:0]  TLS_HANDSHAKE    = 8'h16;
  localparam logic [7:0]  TLS_CLIENT_HELLO = 8'h01;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_CONNECT = 3'd1,
    KIND_DNS     = 3'd2,
    KIND_TLS     = 3'd3,
    KIND_HTTP    = 3'd4
  } kind_t;

  // Packet fields captured through the final byte.
  typedef struct packed {
    logic [3:0]   version;
    logic         bad;
    logic [16:0]  len;
    logic [6:0]   l4;
    logic [7:0]   proto;
    logic [127:0] src;
    logic [127:0] dst;
    logic [31:0]  ports;
    logic [7:0]   flags;
    logic [47:0]  head;
  } pkt_snap_t;

  // HTTP method words: GET, POST, PUT, HEAD, DELE, PATC, OPTI, CONN, TRAC
  function automatic logic is_http(input logic [31:0] w);
    return w == 32'h47455420 || w == 32'h504F5354 || w == 32'h50555420 ||
           w == 32'h48454144 || w == 32'h44454C45 || w == 32'h50415443 ||
           w == 32'h4F505449 || w == 32'h434F4E4E || w == 32'h54524143;
  endfunction

endpackage

// ===== sv/egress_packet_classifier_unit.sv =====
// Top level of the egress packet classifier.
// Throughput: one packet byte per cycle while in_ready is high; a packet yields 0 to 2 result beats.
// Result path: the first result beat passes the snapshot register, then the result buffer
//   (the snapshot waits while the buffer is busy); a second result follows on the next pop.
// in_ready drops only while a finished packet waits for the result buffer to drain.
// Reset (rst_n low, synchronous) clears parser state, the buffer and enforce_enable.
module egress_packet_classifier_unit #(
  parameter int unsigned PAYLOAD_LIMIT = epc_pkg::PAYLOAD_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [2:0]  out_ip_version,
  output logic [63:0] out_src_addr_hi,
  output logic [63:0] out_src_addr_lo,
  output logic [63:0] out_dst_addr_hi,
  output logic [63:0] out_dst_addr_lo,
  output logic [15:0] out_src_port,
  output logic [15:0] out_dst_port,
  output logic [6:0]  out_payload_offset,
  output logic [9:0]  out_payload_length,
  output logic        out_verdict_query,
  output logic        out_last_result
);

  logic               enforce_r;
  logic               snap_valid;
  logic               snap_take;
  epc_pkg::pkt_snap_t snap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enforce_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      enforce_r <= cfg_data;
    end
  end

  epc_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pkt_byte  (in_pkt_byte),
    .in_last_byte (in_last_byte),
    .snap_take    (snap_take),
    .snap_valid   (snap_valid),
    .snap         (snap)
  );

  epc_classify #(
    .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
  ) u_classify (
    .clk                (clk),
    .rst_n              (rst_n),
    .enforce_enable     (enforce_r),
    .snap_valid         (snap_valid),
    .snap               (snap),
    .snap_take          (snap_take),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_ip_version     (out_ip_version),
    .out_src_addr_hi    (out_src_addr_hi),
    .out_src_addr_lo    (out_src_addr_lo),
    .out_dst_addr_hi    (out_dst_addr_hi),
    .out_dst_addr_lo    (out_dst_addr_lo),
    .out_src_port       (out_src_port),
    .out_dst_port       (out_dst_port),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .out_verdict_query  (out_verdict_query),
    .out_last_result    (out_last_result)
  );

endmodule

// ===== sv/epc_parser.sv =====
// Per-byte header parser: captures L3/L4 fields and hands off a packet snapshot.
module epc_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_pkt_byte,
  input  logic               in_last_byte,
  input  logic               snap_take,
  output logic               snap_valid,
  output epc_pkg::pkt_snap_t snap
);

  logic [15:0]  byte_idx_r, byte_idx_nxt;
  logic [3:0]   ver_r, ver_nxt;
  logic [6:0]   l4_r, l4_nxt;
  logic [7:0]   proto_r, proto_nxt;
  logic [127:0] src_r, src_nxt;
  logic [127:0] dst_r, dst_nxt;
  logic [31:0]  ports_r, ports_nxt;
  logic [7:0]   flags_r, flags_nxt;
  logic [47:0]  head_r, head_nxt;
  logic         bad_r, bad_nxt;
  logic         snap_valid_r;
  epc_pkg::pkt_snap_t snap_r, snap_nxt;
  logic         accept;

  assign in_ready   = !snap_valid_r || snap_take;
  assign accept     = in_valid && in_ready;
  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

  always_comb begin
    logic [15:0] rel;
    logic [5:0]  doff;
    logic [3:0]  apos;
    logic [2:0]  hpos;
    byte_idx_nxt = (byte_idx_r != 16'hFFFF) ? byte_idx_r + 16'd1 : byte_idx_r;
    ver_nxt   = ver_r;
    l4_nxt    = l4_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    ports_nxt = ports_r;
    flags_nxt = flags_r;
    head_nxt  = head_r;
    bad_nxt   = bad_r;
    rel  = '0;
    doff = {flags_r[7:4], 2'b00};
    apos = '0;
    hpos = '0;

    if (byte_idx_r == 16'd0) begin
      ver_nxt = in_pkt_byte[7:4];
      if (ver_nxt == epc_pkg::VER_IPV4) begin
        l4_nxt = {1'b0, in_pkt_byte[3:0], 2'b00};
        if (in_pkt_byte[3:0] < 4'd5) bad_nxt = 1'b1;
      end else if (ver_nxt == epc_pkg::VER_IPV6) begin
        l4_nxt = 7'd40;
      end else begin
        bad_nxt = 1'b1;
      end
    end else if (ver_r == epc_pkg::VER_IPV4) begin
      apos = {2'b00, byte_idx_r[1:0]};
      if (byte_idx_r == 16'd9) begin
        proto_nxt = in_pkt_byte;
      end else if (byte_idx_r >= 16'd12 && byte_idx_r < 16'd16) begin
        src_nxt[{~apos, 3'b000} +: 8] = src_r[{~apos, 3'b000} +: 8] | in_pkt_byte;
      end else if (byte_idx_r >= 16'd16 && byte_idx_r < 16'd20) begin
        dst_nxt[{~apos, 3'b000} +: 8] = dst_r[{~apos, 3'b000} +: 8] | in_pkt_byte;
      end
    end else if (ver_r == epc_pkg::VER_IPV6) begin
      apos = {~byte_idx_r[3], byte_idx_r[2:0]};
      if (byte_idx_r == 16'd6) begin
        proto_nxt = in_pkt_byte;
      end else if (byte_idx_r >= 16'd8 && byte_idx_r < 16'd24) begin
        src_nxt[{~apos, 3'b000} +: 8] = src_r[{~apos, 3'b000} +: 8] | in_pkt_byte;
      end else if (byte_idx_r >= 16'd24 && byte_idx_r < 16'd40) begin
        dst_nxt[{~apos, 3'b000} +: 8] = dst_r[{~apos, 3'b000} +: 8] | in_pkt_byte;
      end
    end

    if (!bad_nxt && byte_idx_r >= 16'd20 && byte_idx_r >= {9'd0, l4_nxt}) begin
      rel = byte_idx_r - {9'd0, l4_nxt};
      if (rel < 16'd4) begin
        ports_nxt[{~rel[1:0], 3'b000} +: 8] = ports_r[{~rel[1:0], 3'b000} +: 8] | in_pkt_byte;
      end else if (rel == 16'd12) begin
        flags_nxt = {in_pkt_byte[7:4], flags_r[3:0]};
      end else if (rel == 16'd13) begin
        flags_nxt = {flags_r[7:4], 2'b00, in_pkt_byte[1], in_pkt_byte[4]};
      end else if (rel > 16'd13 && doff >= 6'd20 && rel >= {10'd0, doff} &&
                   rel < {10'd0, doff} + 16'd6) begin
        hpos = 3'(rel - {10'd0, doff});
        hpos = 3'd5 - hpos;
        head_nxt[{hpos, 3'b000} +: 8] = head_r[{hpos, 3'b000} +: 8] | in_pkt_byte;
      end
    end
  end

  always_comb begin
    snap_nxt.version = ver_nxt;
    snap_nxt.bad     = bad_nxt;
    snap_nxt.len     = {1'b0, byte_idx_r} + 17'd1;
    snap_nxt.l4      = l4_nxt;
    snap_nxt.proto   = proto_nxt;
    snap_nxt.src     = src_nxt;
    snap_nxt.dst     = dst_nxt;
    snap_nxt.ports   = ports_nxt;
    snap_nxt.flags   = flags_nxt;
    snap_nxt.head    = head_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r   <= '0;
      ver_r        <= '0;
      l4_r         <= '0;
      proto_r      <= '0;
      src_r        <= '0;
      dst_r        <= '0;
      ports_r      <= '0;
      flags_r      <= '0;
      head_r       <= '0;
      bad_r        <= 1'b0;
      snap_valid_r <= 1'b0;
    end else begin
      if (accept && in_last_byte) begin
        byte_idx_r <= '0;
        ver_r      <= '0;
        l4_r       <= '0;
        proto_r    <= '0;
        src_r      <= '0;
        dst_r      <= '0;
        ports_r    <= '0;
        flags_r    <= '0;
        head_r     <= '0;
        bad_r      <= 1'b0;
      end else if (accept) begin
        byte_idx_r <= byte_idx_nxt;
        ver_r      <= ver_nxt;
        l4_r       <= l4_nxt;
        proto_r    <= proto_nxt;
        src_r      <= src_nxt;
        dst_r      <= dst_nxt;
        ports_r    <= ports_nxt;
        flags_r    <= flags_nxt;
        head_r     <= head_nxt;
        bad_r      <= bad_nxt;
      end
      if (accept && in_last_byte) begin
        snap_valid_r <= 1'b1;
      end else if (snap_take) begin
        snap_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last_byte) begin
      snap_r <= snap_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_byte |=> snap_valid_r && byte_idx_r == 16'd0)
    else $error("final beat did not hand off and clear the parser");

  a_unknown_ver_bad: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r != 16'd0 && ver_r != epc_pkg::VER_IPV4 && ver_r != epc_pkg::VER_IPV6
    |-> bad_r)
    else $error("unknown IP version not marked bad");

  a_take_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    snap_take |-> snap_valid_r)
    else $error("snapshot taken while empty");

endmodule

// ===== sv/epc_classify.sv =====
// End-of-packet classification and the two-deep result buffer.
module epc_classify #(
  parameter int unsigned PAYLOAD_LIMIT = epc_pkg::PAYLOAD_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               enforce_enable,
  input  logic               snap_valid,
  input  epc_pkg::pkt_snap_t snap,
  output logic               snap_take,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_event_kind,
  output logic [2:0]         out_ip_version,
  output logic [63:0]        out_src_addr_hi,
  output logic [63:0]        out_src_addr_lo,
  output logic [63:0]        out_dst_addr_hi,
  output logic [63:0]        out_dst_addr_lo,
  output logic [15:0]        out_src_port,
  output logic [15:0]        out_dst_port,
  output logic [6:0]         out_payload_offset,
  output logic [9:0]         out_payload_length,
  output logic               out_verdict_query,
  output logic               out_last_result
);

  localparam logic [16:0] LIMIT_W = 17'(PAYLOAD_LIMIT);

  logic [1:0]          cnt_r;
  epc_pkg::kind_t      kind0_r, kind1_r;
  logic [2:0]          ver_r;
  logic [127:0]        src_r, dst_r;
  logic [31:0]         ports_r;
  logic [6:0]          off_r;
  logic [9:0]          len_r;
  logic                vq_r;

  logic [1:0]          n_res;
  epc_pkg::kind_t      k0, k1;
  logic [6:0]          ev_off;
  logic [16:0]         ev_avail;
  logic [16:0]         ev_cap;
  logic                ev_vq;
  logic                pop, room, has_pay;

  always_comb begin
    logic        v4, ok, vq, udp, tcp, conn, pay, tls, http, pev;
    logic [5:0]  doff;
    logic [6:0]  dns_off, tcp_off;
    logic [16:0] l4w;
    epc_pkg::kind_t pkind;
    v4   = snap.version == epc_pkg::VER_IPV4;
    l4w  = {10'd0, snap.l4};
    ok   = !snap.bad && (v4 ? snap.len >= 17'd20 : snap.len >= 17'd40) && snap.len >= l4w;
    vq   = v4 && enforce_enable;
    udp  = ok && snap.proto == epc_pkg::PROTO_UDP && snap.len >= l4w + 17'd8;
    tcp  = ok && snap.proto == epc_pkg::PROTO_TCP && snap.len >= l4w + 17'd20;
    doff = {snap.flags[7:4], 2'b00};
    dns_off = snap.l4 + 7'd8;
    tcp_off = snap.l4 + {1'b0, doff};
    conn = snap.flags[1:0] == 2'b10;
    pay  = doff >= 6'd20 && {10'd0, tcp_off} < snap.len &&
           snap.len - {10'd0, tcp_off} >= 17'd6;
    tls  = snap.head[47:40] == epc_pkg::TLS_HANDSHAKE &&
           snap.head[7:0] == epc_pkg::TLS_CLIENT_HELLO;
    http = epc_pkg::is_http(snap.head[47:16]);
    pev  = pay && (tls || http);
    pkind = tls ? epc_pkg::KIND_TLS : epc_pkg::KIND_HTTP;

    n_res  = 2'd0;
    k0     = epc_pkg::KIND_NONE;
    k1     = epc_pkg::KIND_NONE;
    ev_off = '0;
    ev_vq  = vq;
    if (udp) begin
      ev_off = dns_off;
      if (snap.ports[15:0] == epc_pkg::DNS_PORT) begin
        n_res = 2'd1;
        k0    = epc_pkg::KIND_DNS;
        ev_vq = 1'b0;
      end else if (vq) begin
        n_res = 2'd1;
      end
    end else if (tcp) begin
      ev_off = tcp_off;
      if (conn) begin
        k0    = epc_pkg::KIND_CONNECT;
        k1    = pkind;
        n_res = pev ? 2'd2 : 2'd1;
      end else if (pev) begin
        k0    = pkind;
        n_res = 2'd1;
      end else if (vq) begin
        n_res = 2'd1;
      end
    end
    ev_avail = ({10'd0, ev_off} < snap.len) ? snap.len - {10'd0, ev_off} : 17'd0;
    ev_cap   = (ev_avail > LIMIT_W) ? LIMIT_W : ev_avail;
  end

  assign pop       = out_valid && out_ready;
  assign room      = cnt_r == 2'd0 || (cnt_r == 2'd1 && pop);
  assign snap_take = snap_valid && (n_res == 2'd0 || room);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (snap_take && n_res != 2'd0) begin
      cnt_r <= n_res;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take && n_res != 2'd0) begin
      kind0_r <= k0;
      kind1_r <= k1;
      ver_r   <= snap.version[2:0];
      src_r   <= snap.src;
      dst_r   <= snap.dst;
      ports_r <= snap.ports;
      off_r   <= ev_off;
      len_r   <= ev_cap[9:0];
      vq_r    <= ev_vq;
    end else if (pop) begin
      kind0_r <= kind1_r;
    end
  end

  assign has_pay = kind0_r == epc_pkg::KIND_DNS || kind0_r == epc_pkg::KIND_TLS ||
                   kind0_r == epc_pkg::KIND_HTTP;

  assign out_valid          = cnt_r != 2'd0;
  assign out_event_kind     = kind0_r;
  assign out_ip_version     = ver_r;
  assign out_src_addr_hi    = src_r[127:64];
  assign out_src_addr_lo    = src_r[63:0];
  assign out_dst_addr_hi    = dst_r[127:64];
  assign out_dst_addr_lo    = dst_r[63:0];
  assign out_src_port       = ports_r[31:16];
  assign out_dst_port       = ports_r[15:0];
  assign out_payload_offset = has_pay ? off_r : 7'd0;
  assign out_payload_length = has_pay ? len_r : 10'd0;
  assign out_verdict_query  = vq_r;
  assign out_last_result    = cnt_r == 2'd1;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer overfilled");

  a_pair_is_connect: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> kind0_r == epc_pkg::KIND_CONNECT)
    else $error("two results without a leading connect");

  a_none_needs_vq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == epc_pkg::KIND_NONE |-> out_verdict_query)
    else $error("empty result without verdict query");

  a_dns_no_vq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == epc_pkg::KIND_DNS |-> !out_verdict_query)
    else $error("DNS result flagged for verdict query");

endmodule
